// ===== rtl/hsk_pkg.sv =====
`timescale 1ns / 1ps
// hsk_pkg: shared types and constants for the six-key rollover tracker.
// No dependencies; used by every module of the block.
package hsk_pkg;

    // Report geometry and defaults for the top-level parameters
    localparam int OUT_SLOTS             = 6;
    localparam int REPORT_SLOTS_DEFAULT  = 6;
    localparam int LIST_DEPTH_DEFAULT    = 16;
    localparam int ROLLOVER_CODE_DEFAULT = 1;

    // Modifier usages 0xE0..0xE7 share this upper field
    localparam logic [4:0] MOD_PREFIX = 5'b11100;
    localparam logic [7:0] CODE_NONE  = 8'h00;

    // Operation field of an input transaction
    localparam logic OP_PRESS   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Input transaction
    typedef struct packed {
        logic       operation;
        logic [7:0] key_code;
    } t_in;

    // Output transaction (boot-style report)
    typedef struct packed {
        logic [7:0] modifier_mask;
        logic [7:0] slot0;
        logic [7:0] slot1;
        logic [7:0] slot2;
        logic [7:0] slot3;
        logic [7:0] slot4;
        logic [7:0] slot5;
        logic       rollover;
        logic       press_dropped;
    } t_out;

    // Classified command handed from front to back
    typedef enum logic [2:0] {
        K_NONE    = 3'd0,
        K_MOD_SET = 3'd1,
        K_MOD_CLR = 3'd2,
        K_INSERT  = 3'd3,
        K_REMOVE  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] code;
    } t_cmd;

    // Head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

// ===== rtl/hsk_front.sv =====
`timescale 1ns / 1ps
// hsk_front: accepts key events, classifies them and queues the commands.
// Depends on hsk_pkg.
module hsk_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  hsk_pkg::t_in    i_in_data,
    output hsk_pkg::t_q_head o_head,
    input  logic            i_pop
);

    hsk_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_fill;
    hsk_pkg::t_cmd cls;
    logic          push;
    logic          pop;

    // Classify the incoming event
    always_comb begin
        cls.code = i_in_data.key_code;
        if (i_in_data.key_code == hsk_pkg::CODE_NONE) begin
            cls.kind = hsk_pkg::K_NONE;
        end else if (i_in_data.key_code[7:3] == hsk_pkg::MOD_PREFIX) begin
            cls.kind = (i_in_data.operation == hsk_pkg::OP_RELEASE) ?
                       hsk_pkg::K_MOD_CLR : hsk_pkg::K_MOD_SET;
        end else begin
            cls.kind = (i_in_data.operation == hsk_pkg::OP_RELEASE) ?
                       hsk_pkg::K_REMOVE : hsk_pkg::K_INSERT;
        end
    end

    // Two-entry command queue
    assign o_in_stall   = (r_fill == 2'd2);
    assign push         = i_in_valid && !o_in_stall;
    assign o_head.valid = (r_fill != 2'd0);
    assign o_head.cmd   = r_q[r_rp];
    assign pop          = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_fill <= r_fill + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/hsk_back.sv =====
`timescale 1ns / 1ps
// hsk_back: held-key list as a row of cells, modifier mask and report register.
// Depends on hsk_pkg.
module hsk_back #(
    parameter int REPORT_SLOTS  = hsk_pkg::REPORT_SLOTS_DEFAULT,
    parameter int LIST_DEPTH    = hsk_pkg::LIST_DEPTH_DEFAULT,
    parameter int ROLLOVER_CODE = hsk_pkg::ROLLOVER_CODE_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hsk_pkg::t_q_head i_head,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output hsk_pkg::t_out    o_out_data
);

    localparam int CW = $clog2(LIST_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WORK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [7:0]      r_keys [LIST_DEPTH];
    logic [7:0]      n_keys [LIST_DEPTH];
    logic [CW-1:0]   r_count, n_count;
    logic [7:0]      r_mods, n_mods;
    logic            r_dropped, n_dropped;
    hsk_pkg::t_cmd   r_cmd, n_cmd;
    logic            r_out_valid;
    hsk_pkg::t_out   r_out;
    logic            out_load;
    logic [LIST_DEPTH-1:0] match;
    logic [LIST_DEPTH-1:0] at_or_above;
    logic            over;
    logic [7:0]      slot_val [hsk_pkg::OUT_SLOTS];

    // Per-cell match of the released key, and the cells at or above the first match
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        assign match[g] = (32'(g) < 32'(r_count)) && (r_keys[g] == r_cmd.code);
        assign at_or_above[g] = |match[g:0];
    end

    // Sequencer: take a command, apply it, then register the report
    always_comb begin
        n_state   = r_state;
        n_keys    = r_keys;
        n_count   = r_count;
        n_mods    = r_mods;
        n_dropped = r_dropped;
        n_cmd     = r_cmd;
        o_pop     = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop     = 1'b1;
                    n_cmd     = i_head.cmd;
                    n_dropped = 1'b0;
                    n_state   = S_WORK;
                end
            end
            S_WORK: begin
                n_state = S_DONE;
                case (r_cmd.kind)
                    hsk_pkg::K_MOD_SET: begin
                        n_mods = r_mods | (8'd1 << r_cmd.code[2:0]);
                    end
                    hsk_pkg::K_MOD_CLR: begin
                        n_mods = r_mods & ~(8'd1 << r_cmd.code[2:0]);
                    end
                    hsk_pkg::K_INSERT: begin
                        if (r_count == CW'(LIST_DEPTH)) begin
                            n_dropped = 1'b1;
                        end else begin
                            // shift every cell up by one, new key at the front
                            n_keys[0] = r_cmd.code;
                            for (int i = 1; i < LIST_DEPTH; i++) begin
                                n_keys[i] = r_keys[i-1];
                            end
                            n_count = r_count + CW'(1);
                        end
                    end
                    hsk_pkg::K_REMOVE: begin
                        // drop one copy per cycle until none is left
                        if (|match) begin
                            for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                                if (at_or_above[i]) begin
                                    n_keys[i] = r_keys[i+1];
                                end
                            end
                            if (at_or_above[LIST_DEPTH-1]) begin
                                n_keys[LIST_DEPTH-1] = hsk_pkg::CODE_NONE;
                            end
                            n_count = r_count - CW'(1);
                            n_state = S_WORK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    if (i_head.valid) begin
                        o_pop     = 1'b1;
                        n_cmd     = i_head.cmd;
                        n_dropped = 1'b0;
                        n_state   = S_WORK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Report assembly from the settled list
    assign over = 32'(r_count) > 32'(REPORT_SLOTS);
    always_comb begin
        for (int j = 0; j < hsk_pkg::OUT_SLOTS; j++) begin
            if (over) begin
                slot_val[j] = 8'(ROLLOVER_CODE);
            end else if ((j < REPORT_SLOTS) && (32'(j) < 32'(r_count))) begin
                slot_val[j] = r_keys[j];
            end else begin
                slot_val[j] = hsk_pkg::CODE_NONE;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_mods      <= 8'h00;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_mods    <= n_mods;
            r_dropped <= n_dropped;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // List cells, current command and report payload
    always_ff @(posedge i_clk) begin
        r_keys <= n_keys;
        r_cmd  <= n_cmd;
        if (out_load) begin
            r_out.modifier_mask <= r_mods;
            r_out.slot0         <= slot_val[0];
            r_out.slot1         <= slot_val[1];
            r_out.slot2         <= slot_val[2];
            r_out.slot3         <= slot_val[3];
            r_out.slot4         <= slot_val[4];
            r_out.slot5         <= slot_val[5];
            r_out.rollover      <= over;
            r_out.press_dropped <= r_dropped;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/hid_six_key_rollover_tracker.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid / o_in_stall  hsk_pkg::t_in  (operation, key_code)
// out       output     o_out_valid / i_out_stall hsk_pkg::t_out (mask, six slots, flags)
//
// The back end applies an event and then registers the report; a released key
// is applied by removing its held copies one after another in the list
// sequencer of hsk_back. A two-entry command queue parts the input from
// the back end. Reset is synchronous, active low, and empties the list, the
// modifier mask and the queue. A stalled report holds in its output register.
// Top level: front classifier and queue feeding the list back end. Depends on hsk_pkg,
// hsk_front and hsk_back.
module hid_six_key_rollover_tracker #(
    parameter int REPORT_SLOTS  = hsk_pkg::REPORT_SLOTS_DEFAULT,
    parameter int LIST_DEPTH    = hsk_pkg::LIST_DEPTH_DEFAULT,
    parameter int ROLLOVER_CODE = hsk_pkg::ROLLOVER_CODE_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  hsk_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output hsk_pkg::t_out o_out_data
);

    hsk_pkg::t_q_head head;
    logic             pop;

    // Front: classify and queue
    hsk_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_head     (head),
        .i_pop      (pop)
    );

    // Back: key list, modifiers, report
    hsk_back #(
        .REPORT_SLOTS  (REPORT_SLOTS),
        .LIST_DEPTH    (LIST_DEPTH),
        .ROLLOVER_CODE (ROLLOVER_CODE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/hsk_checker.sv =====
`timescale 1ns / 1ps
// hsk_checker: port-level assertions for the rollover tracker, bound to the top.
// Depends on hsk_pkg and hid_six_key_rollover_tracker.
module hsk_checker #(
    parameter int ROLLOVER_CODE = hsk_pkg::ROLLOVER_CODE_DEFAULT
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input hsk_pkg::t_out o_out_data
);

    // No report right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("report valid right after reset");

    // Stalled report stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("report dropped while stalled");

    // Stalled report payload stays put
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("report changed while stalled");

    // Rollover fills every slot with the rollover code
    a_rollover_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.rollover |->
            (o_out_data.slot0 == 8'(ROLLOVER_CODE)) &&
            (o_out_data.slot1 == 8'(ROLLOVER_CODE)) &&
            (o_out_data.slot2 == 8'(ROLLOVER_CODE)) &&
            (o_out_data.slot3 == 8'(ROLLOVER_CODE)) &&
            (o_out_data.slot4 == 8'(ROLLOVER_CODE)) &&
            (o_out_data.slot5 == 8'(ROLLOVER_CODE)))
        else $error("rollover report with a key slot");

    // Without rollover, held keys are packed at the front and zeros follow
    a_zero_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.rollover |->
            ((o_out_data.slot0 != 8'h00) || (o_out_data.slot1 == 8'h00)) &&
            ((o_out_data.slot1 != 8'h00) || (o_out_data.slot2 == 8'h00)) &&
            ((o_out_data.slot2 != 8'h00) || (o_out_data.slot3 == 8'h00)) &&
            ((o_out_data.slot3 != 8'h00) || (o_out_data.slot4 == 8'h00)) &&
            ((o_out_data.slot4 != 8'h00) || (o_out_data.slot5 == 8'h00)))
        else $error("key slot after an empty slot");

endmodule

bind hid_six_key_rollover_tracker hsk_checker #(
    .ROLLOVER_CODE (ROLLOVER_CODE)
) u_hsk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
